/* sv/orthonormal_basis_from_direction_assert.svh */
// Assertion macros for the orthonormal basis block, clocked on clk_i and disabled in reset.
`ifndef ORTHONORMAL_BASIS_FROM_DIRECTION_ASSERT_SVH
`define ORTHONORMAL_BASIS_FROM_DIRECTION_ASSERT_SVH

// same-cycle implication
`define OBFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OBFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/obfd_pkg.sv */
// Shared types, widths and helpers for the orthonormal basis pipeline.
package obfd_pkg;

  localparam int FRAC_BITS_DEF = 14;

  localparam int DIR_W = 16;
  localparam int THR_W = 15;
  localparam int MAG_W = 16;
  localparam int SQ_W  = 31;
  localparam int PP_W  = 2 * SQ_W - 1;
  localparam int S_W   = 32;
  localparam int SS_W  = 2 * S_W - 1;

  localparam int ROOT_STEPS  = MAG_W;
  localparam int PREP_STAGES = 5;
  localparam int ROOT_STAGES = ROOT_STEPS + 1;
  localparam int NUM_STAGES  = PREP_STAGES + ROOT_STAGES + 1;

  localparam logic [THR_W-1:0] AXIS_THRESHOLD_RESET = 15'd11469;
  localparam logic signed [DIR_W-1:0] OUT_MAX = 16'sd32767;

  typedef logic [THR_W-1:0] thr_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] side_x;
    logic signed [DIR_W-1:0] side_y;
    logic signed [DIR_W-1:0] side_z;
    logic signed [DIR_W-1:0] up_x;
    logic signed [DIR_W-1:0] up_y;
    logic signed [DIR_W-1:0] up_z;
    logic                    degenerate;
  } basis_t;

  typedef struct packed {
    logic yz;
    logic neg_a1;
    logic neg_a2;
    logic neg_p1;
    logic neg_p2;
    logic s_zero;
  } ctl_t;

  // width of 4*N^2 over all numerators at a given fraction width
  function automatic int m_width(int frac_bits);
    int base;
    base = SQ_W + 2 * frac_bits + 2;
    return (base > SS_W + 2) ? base : SS_W + 2;
  endfunction

  // apply sign to a rounded magnitude (0..32768), saturating the positive side
  function automatic logic signed [DIR_W-1:0] signed_sat(logic neg, logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] neg_mag;
    neg_mag = ~mag + 1'b1;
    if (neg) begin
      return $signed(neg_mag);
    end else if (mag[MAG_W-1]) begin
      return OUT_MAX;
    end else begin
      return $signed(mag);
    end
  endfunction

endpackage

/* sv/obfd_chan_if.sv */
// Valid/ready channel carrying one payload item.
interface obfd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/obfd_prep.sv */
// Front stages: magnitudes, plane select, squares and products, squared numerators.
module obfd_prep import obfd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MW        = m_width(FRAC_BITS)
) (
  input  logic                   clk_i,
  input  logic [PREP_STAGES-1:0] en_i,
  input  dir_t                   dir_i,
  input  thr_t                   thr_i,
  output ctl_t                   ctl_o,
  output logic [S_W-1:0]         s_o,
  output logic [MW-1:0]          m_a1_o,
  output logic [MW-1:0]          m_a2_o,
  output logic [MW-1:0]          m_p1_o,
  output logic [MW-1:0]          m_p2_o,
  output logic [MW-1:0]          m_l_o
);

  dir_t dir_q;

  logic [DIR_W-1:0] ax, ay, az;
  logic xn, yn, zn, ypos, yz;
  ctl_t ctl1_d, ctl1_q, ctl2_q, ctl3_q, ctl4_d, ctl4_q;

  logic [DIR_W-1:0] b1_q, b2_q, pa1_q, pb1_q, pa2_q, pb2_q;

  logic [2*DIR_W-1:0] sq1_full, sq2_full, p1_full, p2_full;
  logic [SQ_W-1:0]    sq1_q, sq2_q, p1_q, p2_q;

  logic [2*SQ_W-1:0] pp1_full, pp2_full;
  logic [S_W-1:0]    s3_q;
  logic [PP_W-1:0]   pp1_q, pp2_q;
  logic [SQ_W-1:0]   sqa1_q, sqa2_q;

  logic [2*S_W-1:0] ss_full;
  logic [S_W-1:0]   s4_q;
  logic [MW-1:0]    m_a1_q, m_a2_q, m_p1_q, m_p2_q, m_l_q;

  // stage 0: capture
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dir_q <= dir_i;
    end
  end

  // stage 1: magnitudes and plane choice
  always_comb begin
    xn   = dir_q.dir_x[DIR_W-1];
    yn   = dir_q.dir_y[DIR_W-1];
    zn   = dir_q.dir_z[DIR_W-1];
    ax   = xn ? unsigned'(-dir_q.dir_x) : unsigned'(dir_q.dir_x);
    ay   = yn ? unsigned'(-dir_q.dir_y) : unsigned'(dir_q.dir_y);
    az   = zn ? unsigned'(-dir_q.dir_z) : unsigned'(dir_q.dir_z);
    ypos = !yn && (dir_q.dir_y != '0);
    yz   = az > {1'b0, thr_i};
    ctl1_d.yz     = yz;
    ctl1_d.neg_a1 = yz ? zn : ypos;
    ctl1_d.neg_a2 = yz ? ypos : xn;
    ctl1_d.neg_p1 = yz ? (xn ^ yn) : !(zn ^ xn);
    ctl1_d.neg_p2 = yz ? (xn ^ zn) : !(zn ^ yn);
    ctl1_d.s_zero = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctl1_q <= ctl1_d;
      b1_q   <= yz ? ay : ax;
      b2_q   <= yz ? az : ay;
      pa1_q  <= ax;
      pb1_q  <= yz ? ay : az;
      pa2_q  <= yz ? ax : ay;
      pb2_q  <= az;
    end
  end

  // stage 2: squares and cross products
  assign sq1_full = b1_q * b1_q;
  assign sq2_full = b2_q * b2_q;
  assign p1_full  = pa1_q * pb1_q;
  assign p2_full  = pa2_q * pb2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ctl2_q <= ctl1_q;
      sq1_q  <= sq1_full[SQ_W-1:0];
      sq2_q  <= sq2_full[SQ_W-1:0];
      p1_q   <= p1_full[SQ_W-1:0];
      p2_q   <= p2_full[SQ_W-1:0];
    end
  end

  // stage 3: planar length squared, products squared
  assign pp1_full = p1_q * p1_q;
  assign pp2_full = p2_q * p2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ctl3_q <= ctl2_q;
      s3_q   <= {1'b0, sq1_q} + {1'b0, sq2_q};
      pp1_q  <= pp1_full[PP_W-1:0];
      pp2_q  <= pp2_full[PP_W-1:0];
      sqa1_q <= sq2_q;
      sqa2_q <= sq1_q;
    end
  end

  // stage 4: s squared, numerators scaled to 4*N^2
  assign ss_full = s3_q * s3_q;

  always_comb begin
    ctl4_d        = ctl3_q;
    ctl4_d.s_zero = (s3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      ctl4_q <= ctl4_d;
      s4_q   <= s3_q;
      m_a1_q <= MW'(sqa1_q) << (2 * FRAC_BITS + 2);
      m_a2_q <= MW'(sqa2_q) << (2 * FRAC_BITS + 2);
      m_p1_q <= MW'(pp1_q) << 2;
      m_p2_q <= MW'(pp2_q) << 2;
      m_l_q  <= MW'(ss_full[SS_W-1:0]) << 2;
    end
  end

  assign ctl_o  = ctl4_q;
  assign s_o    = s4_q;
  assign m_a1_o = m_a1_q;
  assign m_a2_o = m_a2_q;
  assign m_p1_o = m_p1_q;
  assign m_p2_o = m_p2_q;
  assign m_l_o  = m_l_q;

endmodule

/* sv/obfd_root.sv */
// Pipelined digit recurrence: largest c <= 32768 with (2c-1)^2 * s <= m.
module obfd_root import obfd_pkg::*; #(
  parameter int MW = m_width(FRAC_BITS_DEF)
) (
  input  logic                   clk_i,
  input  logic [ROOT_STAGES-1:0] en_i,
  input  logic [MW-1:0]          m_i,
  input  logic [S_W-1:0]         s_i,
  output logic [MAG_W-1:0]       mag_o
);

  localparam int V_W  = S_W + MAG_W + 1;
  localparam int D_W  = V_W + MAG_W + 1;
  localparam int RW   = ((MW > D_W) ? MW : D_W) + 2;

  // r: residual m - (2c-1)^2 s ; v: (2c-1)s + 2^k s for the next trial bit k
  logic signed [RW-1:0] r_q [ROOT_STAGES-1];
  logic [V_W-1:0]       v_q [ROOT_STAGES-1];
  logic [S_W-1:0]       s_q [ROOT_STAGES-2];
  logic [MAG_W-1:0]     c_q [ROOT_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0] <= $signed(RW'(m_i)) - $signed(RW'(s_i));
      v_q[0] <= (V_W'(s_i) << (MAG_W - 1)) - V_W'(s_i);
      s_q[0] <= s_i;
      c_q[0] <= '0;
    end
  end

  for (genvar j = 1; j < ROOT_STAGES; j++) begin : g_step
    localparam int K = ROOT_STEPS - j;

    logic signed [RW-1:0] trial;
    logic                 acc;

    assign trial = r_q[j-1] - $signed(RW'(v_q[j-1]) << (K + 2));

    if (K == MAG_W - 1) begin : g_top
      assign acc = !trial[RW-1];
    end else begin : g_low
      assign acc = !trial[RW-1] && !c_q[j-1][MAG_W-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        c_q[j] <= c_q[j-1] | (MAG_W'(acc) << K);
      end
    end

    if (K > 0) begin : g_carry
      logic [V_W-1:0] v_d;

      assign v_d = acc ? v_q[j-1] + (V_W'(s_q[j-1]) << K) + (V_W'(s_q[j-1]) << (K - 1))
                       : v_q[j-1] - (V_W'(s_q[j-1]) << (K - 1));

      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          r_q[j] <= acc ? trial : r_q[j-1];
          v_q[j] <= v_d;
        end
      end

      if (K > 1) begin : g_s
        always_ff @(posedge clk_i) begin
          if (en_i[j]) begin
            s_q[j] <= s_q[j-1];
          end
        end
      end
    end
  end

  assign mag_o = c_q[ROOT_STAGES-1];

endmodule

/* sv/orthonormal_basis_from_direction.sv */
// Top level: orthonormal side and up vectors from one Q2.14 direction per item.
//
// dir_i (sink) takes one direction item (dir_x, dir_y, dir_z) per accepted
// valid/ready handshake; basis_o (source) returns one item per direction with
// side_x..up_z and degenerate. cfg_i (sink, always ready) writes axis_threshold;
// write it only while no item is in flight.
// Throughput is one item per cycle while basis_o is not stalled. Each item passes 5
// front stages (capture, magnitudes, squares and products, squared products, s*s),
// 17 root stages (a setup stage, then one bit per stage) and one output register.
// Each stage moves forward when it or any later stage has a free slot, so while
// basis_o is stalled the pipeline keeps filling its bubbles and dir_i stays ready
// until every stage holds an item; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads axis_threshold with 0.7 in Q2.14.
// Zero planar length sets degenerate and zeros all six vector fields.
`include "orthonormal_basis_from_direction_assert.svh"

module orthonormal_basis_from_direction import obfd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  obfd_chan_if.sink   cfg_i,
  obfd_chan_if.sink   dir_i,
  obfd_chan_if.source basis_o
);

  localparam int MW = m_width(FRAC_BITS);

  thr_t thr_q;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  ctl_t           prep_ctl;
  logic [S_W-1:0] prep_s;
  logic [MW-1:0]  m_a1, m_a2, m_p1, m_p2, m_l;

  logic [MAG_W-1:0] mag_a1, mag_a2, mag_p1, mag_p2, mag_l;

  ctl_t ctl_q [ROOT_STAGES];

  logic signed [DIR_W-1:0] a1, a2, p1, p2, ll;
  basis_t out_d, out_q;

  logic out_degen, out_vec_zero;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AXIS_THRESHOLD_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  // stage i advances if any stage from i to the output is empty, or output is taken
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
    assign en[i] = basis_o.ready || !(&vld_q[NUM_STAGES-1:i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= dir_i.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign dir_i.ready = en[0];

  obfd_prep #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_prep (
    .clk_i  (clk_i),
    .en_i   (en[PREP_STAGES-1:0]),
    .dir_i  (dir_i.data),
    .thr_i  (thr_q),
    .ctl_o  (prep_ctl),
    .s_o    (prep_s),
    .m_a1_o (m_a1),
    .m_a2_o (m_a2),
    .m_p1_o (m_p1),
    .m_p2_o (m_p2),
    .m_l_o  (m_l)
  );

  obfd_root #(.MW(MW)) u_root_a1 (
    .clk_i (clk_i), .en_i (en[PREP_STAGES +: ROOT_STAGES]),
    .m_i (m_a1), .s_i (prep_s), .mag_o (mag_a1)
  );

  obfd_root #(.MW(MW)) u_root_a2 (
    .clk_i (clk_i), .en_i (en[PREP_STAGES +: ROOT_STAGES]),
    .m_i (m_a2), .s_i (prep_s), .mag_o (mag_a2)
  );

  obfd_root #(.MW(MW)) u_root_p1 (
    .clk_i (clk_i), .en_i (en[PREP_STAGES +: ROOT_STAGES]),
    .m_i (m_p1), .s_i (prep_s), .mag_o (mag_p1)
  );

  obfd_root #(.MW(MW)) u_root_p2 (
    .clk_i (clk_i), .en_i (en[PREP_STAGES +: ROOT_STAGES]),
    .m_i (m_p2), .s_i (prep_s), .mag_o (mag_p2)
  );

  obfd_root #(.MW(MW)) u_root_l (
    .clk_i (clk_i), .en_i (en[PREP_STAGES +: ROOT_STAGES]),
    .m_i (m_l), .s_i (prep_s), .mag_o (mag_l)
  );

  // control rides alongside the recurrence stages
  always_ff @(posedge clk_i) begin
    if (en[PREP_STAGES]) begin
      ctl_q[0] <= prep_ctl;
    end
    for (int j = 1; j < ROOT_STAGES; j++) begin
      if (en[PREP_STAGES+j]) begin
        ctl_q[j] <= ctl_q[j-1];
      end
    end
  end

  // sign, saturate and place
  always_comb begin
    a1 = signed_sat(ctl_q[ROOT_STAGES-1].neg_a1, mag_a1);
    a2 = signed_sat(ctl_q[ROOT_STAGES-1].neg_a2, mag_a2);
    p1 = signed_sat(ctl_q[ROOT_STAGES-1].neg_p1, mag_p1);
    p2 = signed_sat(ctl_q[ROOT_STAGES-1].neg_p2, mag_p2);
    ll = signed_sat(1'b0, mag_l);
    out_d = '0;
    if (ctl_q[ROOT_STAGES-1].s_zero) begin
      out_d.degenerate = 1'b1;
    end else if (ctl_q[ROOT_STAGES-1].yz) begin
      out_d.side_x = ll;
      out_d.side_y = p1;
      out_d.side_z = p2;
      out_d.up_y   = a1;
      out_d.up_z   = a2;
    end else begin
      out_d.side_x = a1;
      out_d.side_y = a2;
      out_d.up_x   = p1;
      out_d.up_y   = p2;
      out_d.up_z   = ll;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      out_q <= out_d;
    end
  end

  assign basis_o.valid = vld_q[NUM_STAGES-1];
  assign basis_o.data  = out_q;

  assign out_degen    = vld_q[NUM_STAGES-1] && out_q.degenerate;
  assign out_vec_zero = (out_q[$bits(basis_t)-1:1] == '0);

  `OBFD_ASSERT_IMP(a_degen_zero, out_degen, out_vec_zero, "degenerate item, vector not zero")
  `OBFD_ASSERT_IMP(a_ready_drained, !basis_o.valid, dir_i.ready, "input stalled, output empty")
  `OBFD_ASSERT_NXT(a_item_advances, en[1] && vld_q[0], vld_q[1], "item lost between first stages")

endmodule

/* tb/obfd_basis_checker.sv */
// Checker for the orthonormal basis block: predicts each basis item and compares it field by field.
module obfd_basis_checker import obfd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_valid_i,
  input  logic   cfg_ready_i,
  input  thr_t   cfg_data_i,
  input  logic   dir_valid_i,
  input  logic   dir_ready_i,
  input  dir_t   dir_data_i,
  input  logic   basis_valid_i,
  input  logic   basis_ready_i,
  input  basis_t basis_data_i,
  output int     pending_o,
  output int     errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  thr_t   threshold;
  basis_t expected_basis[$];
  basis_t want;
  int     result_count = 0;
  int     mismatches = 0;

  assign errors_o = mismatches;

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // nearest integer to sqrt(num * 2^sh / den), sign applied, positive side saturated
  function automatic logic signed [15:0] root_ratio(input bit neg, input longint unsigned num,
                                                    input int sh, input longint unsigned den);
    logic [127:0] lhs, rhs;
    longint unsigned lo, hi, mid, d;
    if (den == 0) begin
      return '0;
    end
    lo = 0;
    hi = 32768;
    rhs = num;
    rhs = rhs << (sh + 2);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      lhs = d;
      lhs = lhs * d * den;
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (neg) begin
      return 16'(-lo);
    end
    if (lo > 32767) begin
      return OUT_MAX;
    end
    return 16'(lo);
  endfunction

  // nearest integer to sqrt(s), saturated
  function automatic logic signed [15:0] rounded_root(input longint unsigned s);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= s) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (s > lo * lo + lo) begin
      lo++;
    end
    if (lo > 32767) begin
      return OUT_MAX;
    end
    return 16'(lo);
  endfunction

  function automatic basis_t predict_basis(input dir_t d, input thr_t thr);
    basis_t b;
    longint x, y, z;
    longint unsigned ax, ay, az, s, p;
    int sh;
    b = '0;
    x = d.dir_x;
    y = d.dir_y;
    z = d.dir_z;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    sh = 2 * FRAC_BITS;
    if (az > thr) begin
      // y-z plane
      s = ay * ay + az * az;
      if (s == 0) begin
        b.degenerate = 1'b1;
      end else begin
        b.up_y = root_ratio(z < 0, az * az, sh, s);
        b.up_z = root_ratio(y > 0, ay * ay, sh, s);
        b.side_x = rounded_root(s);
        p = ax * ay;
        b.side_y = root_ratio(((x < 0) != (y < 0)) && p != 0, p * p, 0, s);
        p = ax * az;
        b.side_z = root_ratio(((x < 0) != (z < 0)) && p != 0, p * p, 0, s);
      end
    end else begin
      // x-y plane
      s = ax * ax + ay * ay;
      if (s == 0) begin
        b.degenerate = 1'b1;
      end else begin
        b.side_x = root_ratio(y > 0, ay * ay, sh, s);
        b.side_y = root_ratio(x < 0, ax * ax, sh, s);
        p = az * ax;
        b.up_x = root_ratio(((z < 0) == (x < 0)) && p != 0, p * p, 0, s);
        p = az * ay;
        b.up_y = root_ratio(((z < 0) == (y < 0)) && p != 0, p * p, 0, s);
        b.up_z = rounded_root(s);
      end
    end
    return b;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] got,
                             input logic signed [15:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("result %0d %s: got %0d expected %0d", result_count, name, got,
                       exp_val));
    end
  endtask

  task automatic compare_basis(input basis_t got, input basis_t exp_val);
    check_field("side_x", got.side_x, exp_val.side_x);
    check_field("side_y", got.side_y, exp_val.side_y);
    check_field("side_z", got.side_z, exp_val.side_z);
    check_field("up_x", got.up_x, exp_val.up_x);
    check_field("up_y", got.up_y, exp_val.up_y);
    check_field("up_z", got.up_z, exp_val.up_z);
    check_field("degenerate", {15'b0, got.degenerate}, {15'b0, exp_val.degenerate});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold <= AXIS_THRESHOLD_RESET;
      expected_basis.delete();
      pending_o <= 0;
    end else begin
      if (dir_valid_i && dir_ready_i) begin
        expected_basis.push_back(predict_basis(dir_data_i, threshold));
      end
      if (basis_valid_i && basis_ready_i) begin
        if (expected_basis.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_basis.pop_front();
          compare_basis(basis_data_i, want);
        end
        result_count++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        threshold <= cfg_data_i;
      end
      pending_o <= expected_basis.size();
    end
  end

endmodule

/* tb/tb_orthonormal_basis_from_direction.sv */
// Testbench top for orthonormal_basis_from_direction: stimulus, backpressure and verdict.
module tb_orthonormal_basis_from_direction;
  timeunit 1ns;
  timeprecision 1ps;
  import obfd_pkg::*;

  localparam int PIPE_LATENCY   = 22;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 215;

  localparam int DIRECTED [24][3] = '{
    '{0, 0, 0},
    '{0, 0, 11469},
    '{0, 0, 11470},
    '{0, 0, -16384},
    '{0, 0, 16384},
    '{16384, 0, 0},
    '{-16384, 0, 0},
    '{0, 16384, 0},
    '{0, -16384, 0},
    '{3, 4, 0},
    '{-3, -4, 5},
    '{0, 5, -7},
    '{7, 0, -5},
    '{11585, 11585, 0},
    '{9459, 9459, 9459},
    '{5000, -6000, 13000},
    '{-32768, -32768, -32768},
    '{32767, 32767, 0},
    '{-32768, 32767, -32768},
    '{1, 0, 11469},
    '{0, -1, 11469},
    '{1, 1, -1},
    '{-1, -1, 1},
    '{32767, -32768, 32767}
  };

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   errors;
  bit   idle_on;
  bit   stall_on;

  obfd_chan_if #(.T(thr_t))   cfg_if ();
  obfd_chan_if #(.T(dir_t))   dir_if ();
  obfd_chan_if #(.T(basis_t)) basis_if ();

  orthonormal_basis_from_direction i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .dir_i   (dir_if),
    .basis_o (basis_if)
  );

  obfd_basis_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_data_i    (cfg_if.data),
    .dir_valid_i   (dir_if.valid),
    .dir_ready_i   (dir_if.ready),
    .dir_data_i    (dir_if.data),
    .basis_valid_i (basis_if.valid),
    .basis_ready_i (basis_if.ready),
    .basis_data_i  (basis_if.data),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] random_component();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 32768)) - 16384;
      6: v = int'($urandom_range(0, 16)) - 8;
      7: begin
        case ($urandom_range(0, 4))
          0: v = -16384;
          1: v = 16384;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return 16'(v);
  endfunction

  function automatic dir_t random_direction(input thr_t thr);
    dir_t d;
    int v;
    d.dir_x = random_component();
    d.dir_y = random_component();
    d.dir_z = random_component();
    case ($urandom_range(0, 15))
      0: begin
        d.dir_x = '0;
        d.dir_y = '0;
      end
      1, 2: begin
        // z right at the plane selection bound
        v = int'(thr) + int'($urandom_range(0, 2)) - 1;
        d.dir_z = $urandom_range(0, 1) ? 16'(v) : 16'(-v);
      end
      3: begin
        // near the z axis
        d.dir_x = 16'(int'($urandom_range(0, 6)) - 3);
        d.dir_y = 16'(int'($urandom_range(0, 6)) - 3);
      end
      4: d.dir_z = '0;
      default: ;
    endcase
    return d;
  endfunction

  task automatic push_dir(input dir_t d);
    int gap;
    gap = pick_gap(idle_on);
    if (gap > 0) begin
      dir_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dir_if.valid <= 1'b1;
    dir_if.data  <= d;
    @(posedge clk_i);
    while (!dir_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    dir_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input thr_t value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input thr_t thr);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        idle_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      push_dir(random_direction(thr));
    end
  endtask

  // result side backpressure
  initial begin
    int hold;
    hold = 0;
    basis_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        basis_if.ready <= 1'b0;
        hold--;
      end else begin
        basis_if.ready <= 1'b1;
        hold = pick_gap(stall_on);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((dir_if.valid && dir_if.ready) || (basis_if.valid && basis_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    thr_t settings [6];
    dir_t d;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    dir_if.valid <= 1'b0;
    dir_if.data  <= '0;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at the reset threshold
    for (int i = 0; i < 24; i++) begin
      d.dir_x = 16'(DIRECTED[i][0]);
      d.dir_y = 16'(DIRECTED[i][1]);
      d.dir_z = 16'(DIRECTED[i][2]);
      push_dir(d);
    end

    settings[0] = 15'd0;
    settings[1] = 15'd32767;
    settings[2] = 15'd16384;
    settings[3] = 15'($urandom_range(0, 16384));
    settings[4] = 15'd1;
    settings[5] = AXIS_THRESHOLD_RESET;
    foreach (settings[k]) begin
      write_threshold(settings[k]);
      run_random(PHASE_ITEMS, settings[k]);
    end

    drain();
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
